>>> rtl/deadline_timer_slot_table_assert.svh
// Assertion macros for the deadline timer slot table.
// Files that use them provide clk_i and rst_ni; SYNTH removes the checks.
`ifndef DEADLINE_TIMER_SLOT_TABLE_ASSERT_SVH
`define DEADLINE_TIMER_SLOT_TABLE_ASSERT_SVH
`ifndef SYNTH
`define DTST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("deadline timer slot table check failed");
`define DTST_ASSERT_IMP(lbl, ante, cons) \
  `DTST_ASSERT(lbl, (ante) |-> (cons))
`else
`define DTST_ASSERT(lbl, prop)
`define DTST_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> rtl/dtst_pkg.sv
// Shared types and constants of the deadline timer slot table.
// Used by the front, back and top level files and the testbench; depends on nothing.
package dtst_pkg;

  localparam int KEY_W      = 64;
  localparam int SLOT_W     = 4;
  localparam int MAX_FIRES  = 16;
  localparam int FIRE_CNT_W = 4;
  localparam int CMD_DEPTH  = 2;
  localparam int RES_DEPTH  = 4;

  localparam logic [KEY_W-1:0] SIGN_BIT     = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_DISARMED = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] DEADLINE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic {
    OP_ARM = 1'b0,
    OP_RUN = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_NONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_SCAN2,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e               op;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  now_key;
    logic              running;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] fired_slot;
    logic              wake;
    logic [KEY_W-1:0]  next_deadline;
    logic              has_deadline;
    logic              last;
  } res_t;

endpackage

>>> rtl/dtst_fifo.sv
// Small first-in first-out queue of any packed type.
// Depends on nothing; used for the request queue and the result queue.
module dtst_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/dtst_front.sv
// Front end: takes input requests, turns deadlines into ordered keys and queues them.
// Depends on dtst_pkg and dtst_fifo.
module dtst_front #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        opcode_i,
  input  logic [dtst_pkg::SLOT_W-1:0] slot_i,
  input  logic signed [63:0]          deadline_i,
  input  logic signed [63:0]          now_time_i,
  input  logic                        clock_running_i,
  input  logic                        cmd_pop_i,
  output logic                        cmd_valid_o,
  output dtst_pkg::cmd_t              cmd_o
);

  dtst_pkg::cmd_t cmd_in;
  logic           cmd_empty;

  always_comb begin
    cmd_in.op      = dtst_pkg::op_e'(opcode_i);
    cmd_in.slot_ok = (32'(slot_i) < NUM_SLOTS);
    cmd_in.slot    = slot_i;
    cmd_in.key     = deadline_i ^ dtst_pkg::SIGN_BIT;
    cmd_in.now_key = now_time_i ^ dtst_pkg::SIGN_BIT;
    cmd_in.running = clock_running_i;
  end

  dtst_fifo #(
    .T     (dtst_pkg::cmd_t),
    .DEPTH (dtst_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

>>> rtl/dtst_back.sv
// Back end: the slot table memory and the sequencer that scans it and builds results.
// Depends on dtst_pkg.
module dtst_back #(
  parameter int NUM_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  dtst_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output dtst_pkg::res_t res_o
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = IW + 1;

  dtst_pkg::state_e state_q, state_d;

  logic [dtst_pkg::KEY_W-1:0] tbl_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       valid_q;
  logic [dtst_pkg::KEY_W-1:0] rdata_q;
  logic                       rhit_q;

  dtst_pkg::cmd_t               cmd_q;
  logic [CW-1:0]                cnt_q;
  logic                         pend_q;
  logic [IW-1:0]                pidx_q;
  logic [dtst_pkg::KEY_W-1:0]   min_q;
  logic [dtst_pkg::KEY_W-1:0]   due_key_q;
  logic [IW-1:0]                due_idx_q;
  logic                         found_q;
  logic                         wake_q;
  logic [IW-1:0]                fire_q;
  logic                         fired_any_q;
  logic [dtst_pkg::FIRE_CNT_W-1:0] n_q;

  logic                       scan_start, scan_done, scanning, issue;
  logic                       wr_en, fire_load, res_last;
  logic [IW-1:0]              wr_addr;
  logic [dtst_pkg::KEY_W-1:0] wr_key, rkey;
  dtst_pkg::kind_e            kind;

  assign scanning  = (state_q == dtst_pkg::ST_SCAN1) || (state_q == dtst_pkg::ST_SCAN2);
  assign issue     = scanning && (cnt_q < CW'(NUM_SLOTS));
  assign scan_done = (cnt_q == CW'(NUM_SLOTS)) && !pend_q;
  assign rkey      = rhit_q ? rdata_q : dtst_pkg::KEY_DISARMED;

  always_comb begin
    if (cmd_q.op == dtst_pkg::OP_ARM) begin
      kind = dtst_pkg::KIND_ACK;
    end else if (fired_any_q) begin
      kind = dtst_pkg::KIND_FIRED;
    end else begin
      kind = dtst_pkg::KIND_NONE;
    end
    res_last = (kind != dtst_pkg::KIND_FIRED) || !found_q ||
               (n_q == dtst_pkg::FIRE_CNT_W'(dtst_pkg::MAX_FIRES - 1));
    res_o.kind          = kind;
    res_o.fired_slot    = (kind == dtst_pkg::KIND_FIRED) ? dtst_pkg::SLOT_W'(fire_q) : '0;
    res_o.wake          = (kind == dtst_pkg::KIND_ACK) && wake_q;
    res_o.next_deadline = min_q ^ dtst_pkg::SIGN_BIT;
    res_o.has_deadline  = (min_q != dtst_pkg::KEY_DISARMED);
    res_o.last          = res_last;
  end

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    scan_start = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = due_idx_q;
    wr_key     = dtst_pkg::KEY_DISARMED;
    fire_load  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      dtst_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          scan_start = 1'b1;
          state_d    = dtst_pkg::ST_SCAN1;
        end
      end
      dtst_pkg::ST_SCAN1: begin
        if (scan_done) begin
          if (cmd_q.op == dtst_pkg::OP_ARM) begin
            wr_en      = cmd_q.slot_ok;
            wr_addr    = IW'(cmd_q.slot);
            wr_key     = cmd_q.key;
            scan_start = 1'b1;
            state_d    = dtst_pkg::ST_SCAN2;
          end else if (cmd_q.running && found_q) begin
            wr_en      = 1'b1;
            fire_load  = 1'b1;
            scan_start = 1'b1;
            state_d    = dtst_pkg::ST_SCAN2;
          end else begin
            state_d = dtst_pkg::ST_EMIT;
          end
        end
      end
      dtst_pkg::ST_SCAN2: begin
        if (scan_done) begin
          state_d = dtst_pkg::ST_EMIT;
        end
      end
      dtst_pkg::ST_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (res_last) begin
            state_d = dtst_pkg::ST_IDLE;
          end else begin
            wr_en      = 1'b1;
            fire_load  = 1'b1;
            scan_start = 1'b1;
            state_d    = dtst_pkg::ST_SCAN2;
          end
        end
      end
      default: begin
        state_d = dtst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtst_pkg::ST_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      fired_any_q <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_pop_o) begin
        fired_any_q <= 1'b0;
        n_q         <= '0;
      end else if (fire_load) begin
        fired_any_q <= 1'b1;
        if (fired_any_q) begin
          n_q <= n_q + 1'b1;
        end
      end
      if (scan_start) begin
        cnt_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (scanning) begin
        if (issue) begin
          cnt_q <= cnt_q + 1'b1;
        end
        pend_q <= issue;
        if (pend_q && (rkey != dtst_pkg::KEY_DISARMED) && (rkey <= cmd_q.now_key) &&
            (!found_q || (rkey < due_key_q))) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_q[wr_addr] <= wr_key;
    end
    if (issue) begin
      rdata_q <= tbl_q[cnt_q[IW-1:0]];
      rhit_q  <= valid_q[cnt_q[IW-1:0]];
    end
    pidx_q <= cnt_q[IW-1:0];
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (fire_load) begin
      fire_q <= due_idx_q;
    end
    if ((state_q == dtst_pkg::ST_SCAN1) && scan_done) begin
      wake_q <= cmd_q.slot_ok && (cmd_q.key < min_q);
    end
    if (scan_start) begin
      min_q <= dtst_pkg::KEY_DISARMED;
    end else if (scanning && pend_q) begin
      if (rkey < min_q) begin
        min_q <= rkey;
      end
      if ((rkey != dtst_pkg::KEY_DISARMED) && (rkey <= cmd_q.now_key) &&
          (!found_q || (rkey < due_key_q))) begin
        due_key_q <= rkey;
        due_idx_q <= pidx_q;
      end
    end
  end

endmodule

>>> rtl/deadline_timer_slot_table.sv
// Top level of the deadline timer slot table: front end, back end and result queue.
// Depends on dtst_pkg, dtst_front, dtst_back, dtst_fifo and the assertion header.
//
// Requests enter through a queue port: a request is taken at a clock edge with
// push high and full low. Results leave through a queue port: the oldest result
// is shown while empty is low and is taken at an edge with pop high.
// An arm request gives one acknowledge; a run request gives one result per fired
// slot, in deadline order, or a single empty result, and the final one has last set.
// Every request is handled by one sequencer that reads the slot table memory one
// entry per cycle. An arm scans the table, writes the slot, rescans and gives its
// acknowledge; a run that fires nothing scans once and gives its result, and each
// fired slot adds a write that disarms it, a rescan and its result.
// A two-entry request queue lets the next request be taken while one is worked on,
// and a four-entry result queue decouples the receiver; when it fills, the
// sequencer waits and nothing is lost.
// Reset empties both queues and marks every slot disarmed at once through
// per-slot valid bits, so requests are taken in the first cycle after reset.
module deadline_timer_slot_table #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        opcode_i,
  input  logic [dtst_pkg::SLOT_W-1:0] slot_i,
  input  logic signed [63:0]          deadline_i,
  input  logic signed [63:0]          now_time_i,
  input  logic                        clock_running_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  kind_o,
  output logic [dtst_pkg::SLOT_W-1:0] fired_slot_o,
  output logic                        wake_o,
  output logic signed [63:0]          next_deadline_o,
  output logic                        has_deadline_o,
  output logic                        last_o
);

`include "deadline_timer_slot_table_assert.svh"

  logic           cmd_valid, cmd_pop;
  dtst_pkg::cmd_t cmd;
  logic           res_push, res_full;
  dtst_pkg::res_t res_in, res_out;

  dtst_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .opcode_i        (opcode_i),
    .slot_i          (slot_i),
    .deadline_i      (deadline_i),
    .now_time_i      (now_time_i),
    .clock_running_i (clock_running_i),
    .cmd_pop_i       (cmd_pop),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  dtst_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  dtst_fifo #(
    .T     (dtst_pkg::res_t),
    .DEPTH (dtst_pkg::RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign kind_o          = res_out.kind;
  assign fired_slot_o    = res_out.fired_slot;
  assign wake_o          = res_out.wake;
  assign next_deadline_o = res_out.next_deadline;
  assign has_deadline_o  = res_out.has_deadline;
  assign last_o          = res_out.last;

  `DTST_ASSERT_IMP(a_single_result_last, !empty && (kind_o != dtst_pkg::KIND_FIRED), last_o && (fired_slot_o == '0))
  `DTST_ASSERT_IMP(a_wake_on_ack, !empty && wake_o, (kind_o == dtst_pkg::KIND_ACK) && has_deadline_o)
  `DTST_ASSERT_IMP(a_has_matches_next, !empty, has_deadline_o == (next_deadline_o != dtst_pkg::DEADLINE_MAX))

endmodule

>>> verif/deadline_timer_slot_table_tb.sv
// Self-checking testbench for the deadline timer slot table: arm and run requests
// against a predictor of the slot table. Depends on dtst_pkg and the top level RTL.
module deadline_timer_slot_table_tb;

  localparam logic signed [63:0] DL_MAX = dtst_pkg::DEADLINE_MAX;
  localparam logic signed [63:0] DL_MIN = 64'sh8000_0000_0000_0000;
  localparam int NUM_TIMERS = 16;
  localparam int SW = dtst_pkg::SLOT_W;

  typedef struct {
    dtst_pkg::op_e      op;
    logic [SW-1:0]      slot;
    logic signed [63:0] dl;
    logic signed [63:0] now;
    logic               running;
  } timer_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  opcode_i = 1'b0;
  logic [SW-1:0]         slot_i = '0;
  logic signed [63:0]    deadline_i = '0;
  logic signed [63:0]    now_time_i = '0;
  logic                  clock_running_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [1:0]            kind_o;
  logic [SW-1:0]         fired_slot_o;
  logic                  wake_o;
  logic signed [63:0]    next_deadline_o;
  logic                  has_deadline_o;
  logic                  last_o;

  timer_req_t            pending_reqs[$];
  dtst_pkg::res_t        expected_results[$];
  logic signed [63:0]    slot_deadline[NUM_TIMERS];
  logic                  req_taken = 1'b0;
  int                    err_cnt = 0;
  int                    cycle_cnt = 0;
  logic                  hold_off = 1'b0;
  logic                  quiet = 1'b0;

  deadline_timer_slot_table DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .deadline_i     (deadline_i),
    .now_time_i     (now_time_i),
    .clock_running_i(clock_running_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .fired_slot_o   (fired_slot_o),
    .wake_o         (wake_o),
    .next_deadline_o(next_deadline_o),
    .has_deadline_o (has_deadline_o),
    .last_o         (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic idle_now();
    return !quiet && ($urandom_range(0, 99) < 18);
  endfunction

  function automatic logic signed [63:0] earliest_deadline();
    logic signed [63:0] best;
    best = DL_MAX;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (slot_deadline[i] < best) best = slot_deadline[i];
    end
    return best;
  endfunction

  // Lowest armed deadline at or before now; ties go to the lower slot.
  function automatic int due_slot(input logic signed [63:0] now);
    int best;
    best = -1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (slot_deadline[i] != DL_MAX && slot_deadline[i] <= now) begin
        if (best < 0 || slot_deadline[i] < slot_deadline[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic void expect_result(input dtst_pkg::kind_e kind, input int slot,
                                        input logic wake, input logic last);
    dtst_pkg::res_t r;
    r.kind          = kind;
    r.fired_slot    = slot[SW-1:0];
    r.wake          = wake;
    r.next_deadline = earliest_deadline();
    r.has_deadline  = (r.next_deadline != DL_MAX);
    r.last          = last;
    expected_results = {expected_results, r};
  endfunction

  function automatic void predict_request(input timer_req_t r);
    logic signed [63:0] prev_earliest;
    int due;
    int nxt;
    int fires;
    if (r.op == dtst_pkg::OP_ARM) begin
      prev_earliest = earliest_deadline();
      slot_deadline[r.slot] = r.dl;
      expect_result(dtst_pkg::KIND_ACK, 0, r.dl < prev_earliest, 1'b1);
    end else if (!r.running) begin
      expect_result(dtst_pkg::KIND_NONE, 0, 1'b0, 1'b1);
    end else begin
      due = due_slot(r.now);
      fires = 0;
      if (due < 0) expect_result(dtst_pkg::KIND_NONE, 0, 1'b0, 1'b1);
      while (due >= 0 && fires < dtst_pkg::MAX_FIRES) begin
        slot_deadline[due] = DL_MAX;
        fires++;
        nxt = due_slot(r.now);
        expect_result(dtst_pkg::KIND_FIRED, due, 1'b0,
                      nxt < 0 || fires >= dtst_pkg::MAX_FIRES);
        due = nxt;
      end
    end
  endfunction

  function automatic void add_arm(input int slot, input logic signed [63:0] dl);
    timer_req_t r;
    r.op      = dtst_pkg::OP_ARM;
    r.slot    = slot[SW-1:0];
    r.dl      = dl;
    r.now     = rand64();
    r.running = 1'($urandom_range(0, 1));
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void add_run(input logic signed [63:0] now, input logic running);
    timer_req_t r;
    r.op      = dtst_pkg::OP_RUN;
    r.slot    = SW'($urandom_range(0, 15));
    r.dl      = rand64();
    r.now     = now;
    r.running = running;
    pending_reqs = {pending_reqs, r};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
  endtask

  // The receiver holds off for a long stretch early on, and a later window has no idling.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    hold_off  <= (cycle_cnt >= 3000 && cycle_cnt < 3400);
    quiet     <= (cycle_cnt >= 6000 && cycle_cnt < 9000);
  end

  always @(posedge clk_i) begin
    timer_req_t r;
    req_taken <= push && !full;
    if (push && !full) begin
      r.op      = dtst_pkg::op_e'(opcode_i);
      r.slot    = slot_i;
      r.dl      = deadline_i;
      r.now     = now_time_i;
      r.running = clock_running_i;
      predict_request(r);
    end
  end

  always @(negedge clk_i) begin
    timer_req_t r;
    if (rst_ni && (!push || req_taken)) begin
      if (pending_reqs.size() != 0 && !idle_now()) begin
        r = pending_reqs.pop_front();
        opcode_i        <= r.op;
        slot_i          <= r.slot;
        deadline_i      <= r.dl;
        now_time_i      <= r.now;
        clock_running_i <= r.running;
        push            <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && !hold_off && !idle_now();
  end

  always @(posedge clk_i) begin
    dtst_pkg::res_t want;
    if (pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(kind_o), '0);
      end else begin
        want = expected_results.pop_front();
        if (kind_o !== want.kind)
          report_mismatch("kind", 64'(kind_o), 64'(want.kind));
        if (fired_slot_o !== want.fired_slot)
          report_mismatch("fired_slot", 64'(fired_slot_o), 64'(want.fired_slot));
        if (wake_o !== want.wake)
          report_mismatch("wake", 64'(wake_o), 64'(want.wake));
        if (next_deadline_o !== want.next_deadline)
          report_mismatch("next_deadline", next_deadline_o, want.next_deadline);
        if (has_deadline_o !== want.has_deadline)
          report_mismatch("has_deadline", 64'(has_deadline_o), 64'(want.has_deadline));
        if (last_o !== want.last)
          report_mismatch("last", 64'(last_o), 64'(want.last));
      end
    end
  end

  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int pick;
    logic signed [63:0] base;
    logic signed [63:0] dl;
    logic signed [63:0] now;
    for (int i = 0; i < NUM_TIMERS; i++) slot_deadline[i] = DL_MAX;

    // Empty table, stopped clock, ties, disarming and the extremes of time.
    add_run(DL_MAX, 1'b1);
    add_run(DL_MIN, 1'b0);
    add_arm(0, DL_MIN);
    add_arm(15, DL_MAX - 1);
    add_arm(3, 64'sd0);
    add_arm(5, 64'sd0);
    add_arm(7, DL_MAX);
    add_run(DL_MAX, 1'b0);
    add_run(-64'sd1, 1'b1);
    add_run(DL_MAX, 1'b1);
    // Every slot armed, then a single run fires all of them.
    for (int i = 15; i >= 0; i--) add_arm(i, 64'((i % 4) * 100 - 50));
    add_run(DL_MAX, 1'b1);

    base = -64'($urandom_range(0, 100000));
    for (int n = 0; n < 305; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 58) begin
        if (pick < 70) dl = base + 64'($urandom_range(0, 1500));
        else if (pick < 80) dl = DL_MAX;
        else if (pick < 90) dl = rand64();
        else if (pick < 95) dl = DL_MIN;
        else dl = DL_MAX - 1;
        add_arm($urandom_range(0, 15), dl);
      end else begin
        if (pick < 75) begin
          now = base + 64'($urandom_range(0, 1500));
          base = base + 64'($urandom_range(100, 700));
        end else if (pick < 85) begin
          now = DL_MAX;
        end else begin
          now = rand64();
        end
        add_run(now, $urandom_range(0, 99) < 85);
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || push) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/dtst_pkg.sv
rtl/dtst_fifo.sv
rtl/dtst_front.sv
rtl/dtst_back.sv
rtl/deadline_timer_slot_table.sv
verif/deadline_timer_slot_table_tb.sv
